// ===== hw/rtl/gck_pkg.sv =====
// ----------------------------------------------------------------------------
// gck_pkg
// Shared types and constants of the grid cursor key repeat block.
// ----------------------------------------------------------------------------
package gck_pkg;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_PRESS = 2'd1,
        OP_GOTO  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        DIR_UP    = 2'd0,
        DIR_DOWN  = 2'd1,
        DIR_RIGHT = 2'd2,
        DIR_LEFT  = 2'd3
    } dir_t;

    typedef enum logic [2:0] {
        REG_GRID_COLS    = 3'd0,
        REG_GRID_ROWS    = 3'd1,
        REG_VIEW_COLS    = 3'd2,
        REG_VIEW_ROWS    = 3'd3,
        REG_FIRST_DELAY  = 3'd4,
        REG_REPEAT_DELAY = 3'd5,
        REG_ALPHA_MIN    = 3'd6,
        REG_ALPHA_MAX    = 3'd7
    } reg_idx_t;

    localparam logic [8:0]  GRID_COLS_RST    = 9'd10;
    localparam logic [8:0]  GRID_ROWS_RST    = 9'd10;
    localparam logic [8:0]  VIEW_COLS_RST    = 9'd10;
    localparam logic [8:0]  VIEW_ROWS_RST    = 9'd10;
    localparam logic [15:0] FIRST_DELAY_RST  = 16'd20;
    localparam logic [15:0] REPEAT_DELAY_RST = 16'd5;
    localparam logic [7:0]  ALPHA_MIN_RST    = 8'd64;
    localparam logic [7:0]  ALPHA_MAX_RST    = 8'd255;

    typedef struct packed {
        logic [8:0]  grid_cols;
        logic [8:0]  grid_rows;
        logic [8:0]  view_cols;
        logic [8:0]  view_rows;
        logic [15:0] first_delay;
        logic [15:0] repeat_delay;
        logic [7:0]  alpha_min;
        logic [7:0]  alpha_max;
    } cfg_t;

    typedef struct packed {
        logic [7:0] goto_y;
        logic [7:0] goto_x;
        logic [1:0] press_dir;
        logic [3:0] held_mask;
        logic [1:0] op;
    } item_t;

    typedef struct packed {
        logic       moved;
        logic [7:0] alpha;
        logic [7:0] view_y;
        logic [7:0] view_x;
        logic [7:0] cursor_y;
        logic [7:0] cursor_x;
    } res_t;

endpackage

// ===== hw/rtl/gck_cfg.sv =====
// ----------------------------------------------------------------------------
// gck_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module gck_cfg (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           we,
    input  logic [2:0]     index,
    input  logic [15:0]    wdata,
    output gck_pkg::cfg_t  cfg
);
    import gck_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (we)
        begin
            unique case (reg_idx_t'(index))
                REG_GRID_COLS:    cfg_next.grid_cols    = wdata[8:0];
                REG_GRID_ROWS:    cfg_next.grid_rows    = wdata[8:0];
                REG_VIEW_COLS:    cfg_next.view_cols    = wdata[8:0];
                REG_VIEW_ROWS:    cfg_next.view_rows    = wdata[8:0];
                REG_FIRST_DELAY:  cfg_next.first_delay  = wdata;
                REG_REPEAT_DELAY: cfg_next.repeat_delay = wdata;
                REG_ALPHA_MIN:    cfg_next.alpha_min    = wdata[7:0];
                REG_ALPHA_MAX:    cfg_next.alpha_max    = wdata[7:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.grid_cols    <= GRID_COLS_RST;
            cfg_reg.grid_rows    <= GRID_ROWS_RST;
            cfg_reg.view_cols    <= VIEW_COLS_RST;
            cfg_reg.view_rows    <= VIEW_ROWS_RST;
            cfg_reg.first_delay  <= FIRST_DELAY_RST;
            cfg_reg.repeat_delay <= REPEAT_DELAY_RST;
            cfg_reg.alpha_min    <= ALPHA_MIN_RST;
            cfg_reg.alpha_max    <= ALPHA_MAX_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/gck_engine.sv =====
// ----------------------------------------------------------------------------
// gck_engine
// Cursor, view, hold timer and fade state with the single-pass update logic.
// ----------------------------------------------------------------------------
module gck_engine #(
    parameter int MAX_DIM    = 256,
    parameter int ALPHA_STEP = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  gck_pkg::item_t item,
    input  gck_pkg::cfg_t  cfg,
    output gck_pkg::res_t  res
);
    import gck_pkg::*;

    localparam logic [8:0] DIM_CAP = (MAX_DIM < 256) ? 9'(MAX_DIM) : 9'd256;
    localparam logic signed [9:0] STEP = 10'(ALPHA_STEP);

    typedef struct packed {
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] ox;
        logic [7:0] oy;
        logic       mv;
    } cur_t;

    typedef struct packed {
        logic [8:0] gc_m1;
        logic [8:0] gr_m1;
        logic [8:0] vc;
        logic [8:0] vr;
        logic       scroll;
    } geo_t;

    function automatic logic [8:0] eff_dim(logic [8:0] v);
        if (v == 9'd0)
            return 9'd1;
        else if (v > DIM_CAP)
            return DIM_CAP;
        else
            return v;
    endfunction

    function automatic logic [7:0] follow(logic [7:0] p, logic [7:0] org, logic [8:0] view);
        logic [9:0] lim;
        logic [9:0] dif;
        lim = {2'b00, org} + {1'b0, view};
        dif = {2'b00, p} - {1'b0, view} + 10'd1;
        if (p < org)
            return p;
        else if ({2'b00, p} >= lim)
            return dif[7:0];
        else
            return org;
    endfunction

    function automatic cur_t do_move(cur_t s, dir_t dir, logic wrap, geo_t g);
        cur_t r;
        r = s;
        r.mv = 1'b0;
        unique case (dir)
            DIR_UP:
            begin
                if (s.y == 8'd0)
                begin
                    if (wrap)
                    begin
                        r.y  = g.gr_m1[7:0];
                        r.mv = 1'b1;
                    end
                end
                else
                begin
                    r.y  = s.y - 8'd1;
                    r.mv = 1'b1;
                end
            end
            DIR_DOWN:
            begin
                if ({1'b0, s.y} >= g.gr_m1)
                begin
                    if (wrap)
                    begin
                        r.y  = 8'd0;
                        r.mv = 1'b1;
                    end
                end
                else
                begin
                    r.y  = s.y + 8'd1;
                    r.mv = 1'b1;
                end
            end
            DIR_RIGHT:
            begin
                if ({1'b0, s.x} >= g.gc_m1)
                begin
                    if (wrap)
                    begin
                        r.x  = 8'd0;
                        r.mv = 1'b1;
                    end
                end
                else
                begin
                    r.x  = s.x + 8'd1;
                    r.mv = 1'b1;
                end
            end
            default:
            begin
                if (s.x == 8'd0)
                begin
                    if (wrap)
                    begin
                        r.x  = g.gc_m1[7:0];
                        r.mv = 1'b1;
                    end
                end
                else
                begin
                    r.x  = s.x - 8'd1;
                    r.mv = 1'b1;
                end
            end
        endcase
        if (r.mv && g.scroll)
        begin
            r.ox = follow(r.x, r.ox, g.vc);
            r.oy = follow(r.y, r.oy, g.vr);
        end
        return r;
    endfunction

    logic [7:0]  pos_x_reg;
    logic [7:0]  pos_y_reg;
    logic [7:0]  org_x_reg;
    logic [7:0]  org_y_reg;
    logic [15:0] timer_reg [4];
    logic [15:0] timer_next [4];
    logic [7:0]  fade_level_reg;
    logic [7:0]  fade_level_next;
    logic        fade_rising_reg;
    logic        fade_rising_next;
    cur_t        cur_next;
    logic        moved;
    geo_t        geo;
    logic [8:0]  gc;
    logic [8:0]  gr;
    logic [8:0]  vc;
    logic [8:0]  vr;

    assign gc = eff_dim(cfg.grid_cols);
    assign gr = eff_dim(cfg.grid_rows);
    assign vc = eff_dim(cfg.view_cols);
    assign vr = eff_dim(cfg.view_rows);

    assign geo.gc_m1  = gc - 9'd1;
    assign geo.gr_m1  = gr - 9'd1;
    assign geo.vc     = vc;
    assign geo.vr     = vr;
    assign geo.scroll = (gc > vc) || (gr > vr);

    always_comb
    begin
        cur_t             cur0;
        cur_t             c;
        logic [15:0]      tm1;
        logic             fire;
        logic             any_mv;
        logic [7:0]       lvl;
        logic             rise;
        logic signed [9:0] v;

        cur0 = '{x: pos_x_reg, y: pos_y_reg, ox: org_x_reg, oy: org_y_reg, mv: 1'b0};
        c      = cur0;
        any_mv = 1'b0;
        lvl    = fade_level_reg;
        rise   = fade_rising_reg;
        v      = '0;
        tm1    = '0;
        fire   = 1'b0;
        for (int d = 0; d < 4; d++)
        begin
            timer_next[d] = timer_reg[d];
        end

        unique case (item.op)
            OP_TICK:
            begin
                for (int d = 0; d < 4; d++)
                begin
                    fire = 1'b0;
                    tm1  = timer_reg[d] - 16'd1;
                    if (item.held_mask[d])
                    begin
                        if (timer_reg[d] != 16'd0)
                        begin
                            if (tm1 == 16'd0)
                            begin
                                fire          = 1'b1;
                                timer_next[d] = cfg.repeat_delay;
                            end
                            else
                            begin
                                timer_next[d] = tm1;
                            end
                        end
                        else
                        begin
                            timer_next[d] = cfg.first_delay;
                        end
                    end
                    else
                    begin
                        timer_next[d] = 16'd0;
                    end
                    if (fire)
                    begin
                        c      = do_move(c, dir_t'(2'(d)), 1'b0, geo);
                        any_mv = any_mv | c.mv;
                    end
                end
                if (any_mv)
                begin
                    lvl  = cfg.alpha_max;
                    rise = 1'b0;
                end
                v = rise ? ($signed({2'b00, lvl}) + STEP) : ($signed({2'b00, lvl}) - STEP);
                priority if (v > $signed({2'b00, cfg.alpha_max}))
                begin
                    lvl  = cfg.alpha_max;
                    rise = 1'b0;
                end
                else if (v < $signed({2'b00, cfg.alpha_min}))
                begin
                    lvl  = cfg.alpha_min;
                    rise = 1'b1;
                end
                else
                begin
                    lvl = v[7:0];
                end
            end
            OP_PRESS:
            begin
                c      = do_move(cur0, dir_t'(item.press_dir), 1'b1, geo);
                any_mv = c.mv;
                if (c.mv)
                begin
                    lvl  = cfg.alpha_max;
                    rise = 1'b0;
                end
            end
            OP_GOTO:
            begin
                c.x = ({1'b0, item.goto_x} < gc) ? item.goto_x : geo.gc_m1[7:0];
                c.y = ({1'b0, item.goto_y} < gr) ? item.goto_y : geo.gr_m1[7:0];
                if (geo.scroll)
                begin
                    c.ox = follow(c.x, c.ox, vc);
                    c.oy = follow(c.y, c.oy, vr);
                end
                lvl  = cfg.alpha_max;
                rise = 1'b0;
            end
            default:
            begin
                c = cur0;
            end
        endcase

        cur_next         = c;
        moved            = any_mv;
        fade_level_next  = lvl;
        fade_rising_next = rise;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg       <= 8'd0;
            pos_y_reg       <= 8'd0;
            org_x_reg       <= 8'd0;
            org_y_reg       <= 8'd0;
            fade_level_reg  <= ALPHA_MAX_RST;
            fade_rising_reg <= 1'b0;
            for (int d = 0; d < 4; d++)
            begin
                timer_reg[d] <= 16'd0;
            end
        end
        else if (en)
        begin
            pos_x_reg       <= cur_next.x;
            pos_y_reg       <= cur_next.y;
            org_x_reg       <= cur_next.ox;
            org_y_reg       <= cur_next.oy;
            fade_level_reg  <= fade_level_next;
            fade_rising_reg <= fade_rising_next;
            for (int d = 0; d < 4; d++)
            begin
                timer_reg[d] <= timer_next[d];
            end
        end
    end

    assign res.cursor_x = cur_next.x;
    assign res.cursor_y = cur_next.y;
    assign res.view_x   = cur_next.ox;
    assign res.view_y   = cur_next.oy;
    assign res.alpha    = fade_level_next;
    assign res.moved    = moved;

endmodule

// ===== hw/rtl/grid_cursor_key_repeat_core.sv =====
// ----------------------------------------------------------------------------
// grid_cursor_key_repeat_core
// Grid cursor with typematic key repeat, scrolling view and pulsing alpha.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream s_* carries one item per transfer: a tick with the held-key
//   mask, a direction press, or a goto. Master stream m_* returns exactly one
//   result item per input item, in order: cursor, view origin, alpha and the
//   moved flag that triggers the key-click sound.
//   Configuration registers are written through cfg_we / cfg_index /
//   cfg_wdata, one register per cycle; the user must write them only while
//   no item is in flight, which the block itself leaves unenforced.
//   Throughput: one item per cycle while the receiver takes results; the
//   input register and the result register form a two-stage pipe with the
//   state update between them, and m_* is driven by the result register.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more item; s_tready falls only when both are
//   full.
//   Reset clears the cursor, view origin and hold timers, sets alpha to its
//   maximum (falling) and loads the configuration defaults.
// ----------------------------------------------------------------------------
module grid_cursor_key_repeat_core #(
    parameter int MAX_DIM    = 256,
    parameter int ALPHA_STEP = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // held_mask[3:0], press_dir[5:4],
                                   // goto_x[13:6], goto_y[21:14], zeros
    input  logic [1:0]  s_tuser,   // op[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // cursor_x[7:0], cursor_y[15:8], view_x[23:16],
                                   // view_y[31:24], alpha[39:32], moved[40], zeros
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);
    import gck_pkg::*;

    item_t in_reg;
    logic  in_valid_reg;
    logic  in_valid_next;
    res_t  out_reg;
    logic  out_valid_reg;
    logic  out_valid_next;
    logic  advance;
    cfg_t  cfg;
    res_t  res;

    gck_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (cfg_we),
        .index (cfg_index),
        .wdata (cfg_wdata),
        .cfg   (cfg)
    );

    gck_engine #(
        .MAX_DIM    (MAX_DIM),
        .ALPHA_STEP (ALPHA_STEP)
    ) u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (advance),
        .item  (in_reg),
        .cfg   (cfg),
        .res   (res)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
        out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_reg <= item_t'({s_tdata[21:0], s_tuser});
        end
        if (advance)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_reg};

`ifndef SYNTH
    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("input register lost an item while stalled");

    a_advance_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_tvalid)
        else $error("result not presented after advance");

    a_ready_low_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready)
        else $error("input stalled while pipe has room");

    a_goto_no_sound: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (in_reg.op == OP_GOTO) |=> !out_reg.moved)
        else $error("goto raised the moved flag");
`endif

endmodule
